[design/rpc_pkg.sv]
package rpc_pkg;

  // Core sizing
  localparam int ITERATIONS = 24;
  localparam int FRAC_BITS  = 16;
  localparam int GUARD      = 16;

  localparam int IN_W  = 31;
  localparam int OUT_W = 32;
  localparam int AW    = IN_W + 1;        // operand after negation
  localparam int KW    = 30;              // gain magnitude bits (Q.30, below one)
  localparam int PW    = AW + KW + 1;     // operand times gain
  localparam int XW    = GUARD + 34;      // x/y datapath with guard bits
  localparam int ZW    = 35;              // angle accumulator, radians Q.30
  localparam int TW    = 34;              // angle bits fed to degree conversion
  localparam int SH_IN = 30 - GUARD;

  // Angle constants
  localparam logic signed [ZW-1:0] PI_Q30 = ZW'(64'sd3373259426);
  localparam int DRW = 28;
  localparam logic signed [DRW-1:0] DEG2RAD_S = DRW'(74961321);
  localparam int RDW = 31;
  localparam logic signed [RDW-1:0] RAD2DEG_S = RDW'(961263669);
  localparam int DEG_SH = FRAC_BITS + 2;
  localparam int RAD_SH = 54 - FRAC_BITS;
  localparam int TPW    = TW + RDW;

  localparam int ATAN_DEPTH = 32;
  localparam logic [29:0] ATAN_Q30 [ATAN_DEPTH] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd7, 30'd3, 30'd1, 30'd0, 30'd0
  };

  // Integer square root, bit pair at a time
  function automatic logic [63:0] isqrt64(input logic [63:0] op_in);
    logic [63:0] op;
    logic [63:0] res;
    logic [63:0] one;
    op  = op_in;
    res = '0;
    one = 64'd1 << 62;
    while (one > op) one = one >> 2;
    while (one != 64'd0) begin
      if (op >= res + one) begin
        op  = op - (res + one);
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one = one >> 2;
    end
    return res;
  endfunction

  // Gain compensation K in Q.30: product of stage factors, root, then
  // rounded reciprocal by restoring long division
  function automatic logic [63:0] gain_q30();
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] q;
    p = 64'd1 << 60;
    for (int i = 0; i < ITERATIONS; i++) p = p + (p >> (2 * i));
    s   = isqrt64(p);
    num = (64'd1 << 60) + (s >> 1);
    rem = '0;
    q   = '0;
    for (int n = 63; n >= 0; n--) begin
      rem = {rem[62:0], num[n]};
      if (rem >= s) begin
        rem  = rem - s;
        q[n] = 1'b1;
      end
    end
    return q;
  endfunction

  localparam logic [KW-1:0] GAIN = KW'(gain_q30());
  localparam logic signed [KW:0] GAIN_S = signed'({1'b0, GAIN});

  // Angle reduction modulo 360 degrees = 45 * 2^(FRAC_BITS+3)
  localparam int RED_SH = FRAC_BITS + 3;
  localparam int H_W    = IN_W - RED_SH;
  localparam int HP_W   = H_W + 1;
  localparam int H_OFS  = 45 * (((1 << (H_W - 1)) + 44) / 45);
  localparam int RK     = H_W + 7;
  localparam int RW     = RK - 4;
  localparam logic [RW-1:0] RECIP_U = RW'(((1 << RK) + 44) / 45);
  localparam logic [HP_W-1:0] MOD45 = HP_W'(45);
  localparam int RES_W  = RED_SH + 6;
  localparam int MODW   = RES_W + 1;
  localparam logic [RES_W-1:0] HALF_U = RES_W'(180 << FRAC_BITS);
  localparam logic signed [MODW-1:0] FULL_S    = MODW'(360 << FRAC_BITS);
  localparam logic signed [MODW-1:0] HALF_S    = MODW'(180 << FRAC_BITS);
  localparam logic signed [MODW-1:0] QUARTER_S = MODW'(90 << FRAC_BITS);
  localparam int ZPW = MODW + DRW;

  // Degree output limit
  localparam logic signed [OUT_W-1:0] LIM_S = OUT_W'(180 << FRAC_BITS);

  localparam int PREP_STAGES = 7;

  // Word passed between the front end, the rotator and the back end
  typedef struct packed {
    logic                 kind;
    logic                 origin;
    logic                 flip;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cord_t;

endpackage

[design/rpc_prep.sv]
module rpc_prep (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         kind,
  input  logic signed [rpc_pkg::IN_W-1:0] first_operand,
  input  logic signed [rpc_pkg::IN_W-1:0] second_operand,
  output logic                         out_valid,
  input  logic                         out_ready,
  output rpc_pkg::cord_t               out_data
);
  import rpc_pkg::*;

  typedef struct packed {
    logic                   kind;
    logic                   origin;
    logic                   flip;
    logic signed [AW-1:0]   aa;
    logic signed [AW-1:0]   bb;
    logic signed [ZW-1:0]   z;
    logic [HP_W-1:0]        hp;
    logic [RED_SH-1:0]      lo;
    logic signed [PW-1:0]   px;
    logic signed [PW-1:0]   py;
    logic [HP_W-1:0]        q;
    logic [RES_W-1:0]       res;
    logic signed [MODW-1:0] m;
    logic signed [ZPW-1:0]  zp;
    logic signed [XW-1:0]   x;
    logic signed [XW-1:0]   y;
  } prep_t;

  prep_t st [PREP_STAGES];
  prep_t st_next [PREP_STAGES];
  logic [PREP_STAGES-1:0] v;
  logic [PREP_STAGES-1:0] en;
  logic [PREP_STAGES-1:0] vin;

  // Stage 0: left half-plane fold, origin detect, split angle for reduction
  always_comb begin
    logic signed [AW-1:0] a_ext;
    logic signed [AW-1:0] b_ext;
    logic                 neg;
    a_ext = AW'(first_operand);
    b_ext = AW'(second_operand);
    neg   = !kind && first_operand[IN_W-1];
    st_next[0]        = '0;
    st_next[0].kind   = kind;
    st_next[0].origin = !kind && (first_operand == '0) && (second_operand == '0);
    st_next[0].aa     = neg ? -a_ext : a_ext;
    st_next[0].bb     = neg ? -b_ext : b_ext;
    st_next[0].z      = neg ? (second_operand[IN_W-1] ? -PI_Q30 : PI_Q30) : '0;
    st_next[0].hp     = HP_W'(signed'(second_operand[IN_W-1:RED_SH])) + HP_W'(H_OFS);
    st_next[0].lo     = second_operand[RED_SH-1:0];
  end

  // Stage 1: gain multiplies, reciprocal multiply for the modulo
  always_comb begin
    logic [HP_W+RW-1:0] qp;
    qp = (HP_W+RW)'(st[0].hp) * (HP_W+RW)'(RECIP_U);
    st_next[1]    = st[0];
    st_next[1].px = PW'(st[0].aa) * PW'(GAIN_S);
    st_next[1].py = st[0].kind ? '0 : PW'(st[0].bb) * PW'(GAIN_S);
    st_next[1].q  = HP_W'(qp >> RK);
  end

  // Stage 2: round to guard bits, finish the modulo
  always_comb begin
    logic [HP_W-1:0] r;
    r = st[1].hp - st[1].q * MOD45;
    if (r >= MOD45) r = r - MOD45;
    st_next[2]     = st[1];
    st_next[2].x   = XW'((st[1].px + (PW'(1) <<< (SH_IN - 1))) >>> SH_IN);
    st_next[2].y   = XW'((st[1].py + (PW'(1) <<< (SH_IN - 1))) >>> SH_IN);
    st_next[2].res = {r[5:0], st[1].lo};
  end

  // Stage 3: center the residue on zero
  always_comb begin
    logic signed [MODW-1:0] rs;
    rs = signed'({1'b0, st[2].res});
    st_next[3]   = st[2];
    st_next[3].m = (st[2].res > HALF_U) ? rs - FULL_S : rs;
  end

  // Stage 4: fold into the right half-plane, remember to negate
  always_comb begin
    st_next[4] = st[3];
    if (st[3].m > QUARTER_S) begin
      st_next[4].m    = st[3].m - HALF_S;
      st_next[4].flip = st[3].kind;
    end else if (st[3].m < -QUARTER_S) begin
      st_next[4].m    = st[3].m + HALF_S;
      st_next[4].flip = st[3].kind;
    end
  end

  // Stage 5: degrees to radians
  always_comb begin
    st_next[5]    = st[4];
    st_next[5].zp = ZPW'(st[4].m) * ZPW'(DEG2RAD_S);
  end

  // Stage 6: round the start angle, pick per mode
  always_comb begin
    st_next[6] = st[5];
    if (st[5].kind) begin
      st_next[6].z = ZW'((st[5].zp + (ZPW'(1) <<< (DEG_SH - 1))) >>> DEG_SH);
      st_next[6].y = '0;
    end
  end

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[PREP_STAGES-1] = !v[PREP_STAGES-1] || out_ready;
    for (int i = PREP_STAGES - 2; i >= 0; i--) en[i] = !v[i] || en[i+1];
  end

  assign vin      = {v[PREP_STAGES-2:0], in_valid};
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    for (int i = 0; i < PREP_STAGES; i++) begin
      if (en[i]) st[i] <= st_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < PREP_STAGES; i++) begin
        if (en[i]) v[i] <= vin[i];
      end
    end
  end

  assign out_valid       = v[PREP_STAGES-1];
  assign out_data.kind   = st[PREP_STAGES-1].kind;
  assign out_data.origin = st[PREP_STAGES-1].origin;
  assign out_data.flip   = st[PREP_STAGES-1].flip;
  assign out_data.x      = st[PREP_STAGES-1].x;
  assign out_data.y      = st[PREP_STAGES-1].y;
  assign out_data.z      = st[PREP_STAGES-1].z;

  // Folded polar angle must sit within a quarter turn
  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    (v[4] && st[4].kind) |-> (st[4].m <= QUARTER_S && st[4].m >= -QUARTER_S))
    else $error("polar angle fold out of range");

  // A held first stage keeps its word
  a_head_hold: assert property (@(posedge clk) disable iff (rst)
    (v[0] && !en[0]) |=> (v[0] && $stable(st[0])))
    else $error("front stage lost word while stalled");

endmodule

[design/rpc_cordic.sv]
module rpc_cordic (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rpc_pkg::cord_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rpc_pkg::cord_t out_data
);
  import rpc_pkg::*;

  cord_t src [ITERATIONS];
  cord_t st [ITERATIONS];
  cord_t st_next [ITERATIONS];
  logic [ITERATIONS-1:0] v;
  logic [ITERATIONS-1:0] en;
  logic [ITERATIONS-1:0] vin;

  assign src[0] = in_data;

  // One micro-rotation per stage
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    if (i > 0) begin : g_link
      assign src[i] = st[i-1];
    end

    always_comb begin
      logic signed [XW-1:0] xs;
      logic signed [XW-1:0] ys;
      logic signed [ZW-1:0] ang;
      logic                 up;
      logic                 rot_pos;
      xs      = $signed(src[i].x) >>> i;
      ys      = $signed(src[i].y) >>> i;
      ang     = ZW'(ATAN_Q30[i]);
      up      = src[i].kind ? !src[i].z[ZW-1] : !src[i].y[XW-1];
      rot_pos = src[i].kind ? up : !up;
      st_next[i] = src[i];
      if (rot_pos) begin
        st_next[i].x = src[i].x - ys;
        st_next[i].y = src[i].y + xs;
        st_next[i].z = src[i].z - ang;
      end else begin
        st_next[i].x = src[i].x + ys;
        st_next[i].y = src[i].y - xs;
        st_next[i].z = src[i].z + ang;
      end
    end
  end

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[ITERATIONS-1] = !v[ITERATIONS-1] || out_ready;
    for (int i = ITERATIONS - 2; i >= 0; i--) en[i] = !v[i] || en[i+1];
  end

  assign vin      = {v[ITERATIONS-2:0], in_valid};
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    for (int i = 0; i < ITERATIONS; i++) begin
      if (en[i]) st[i] <= st_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < ITERATIONS; i++) begin
        if (en[i]) v[i] <= vin[i];
      end
    end
  end

  assign out_valid = v[ITERATIONS-1];
  assign out_data  = st[ITERATIONS-1];

  // Last rotator stage holds its word while the back end stalls
  a_tail_hold: assert property (@(posedge clk) disable iff (rst)
    (v[ITERATIONS-1] && !out_ready) |=> (v[ITERATIONS-1] && $stable(st[ITERATIONS-1])))
    else $error("rotator dropped word under stall");

endmodule

[design/rpc_post.sv]
module rpc_post (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rpc_pkg::cord_t                 in_data,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic signed [rpc_pkg::OUT_W-1:0] first_result,
  output logic signed [rpc_pkg::OUT_W-1:0] second_result
);
  import rpc_pkg::*;

  typedef struct packed {
    logic                  kind;
    logic                  origin;
    logic signed [TPW-1:0] tp;
    logic signed [XW-1:0]  xf;
    logic signed [XW-1:0]  yf;
  } post_t;

  post_t p1;
  post_t p1_next;
  logic  v1;
  logic  en1;
  logic  en2;
  logic signed [OUT_W-1:0] first_next;
  logic signed [OUT_W-1:0] second_next;

  // Drop guard bits with round half up, saturate to the output width
  function automatic logic signed [OUT_W-1:0] sat_round(input logic signed [XW-1:0] val);
    logic signed [XW:0] r;
    r = ((XW+1)'(val) + ((XW+1)'(1) <<< (GUARD - 1))) >>> GUARD;
    if (r > (XW+1)'(32'sh7FFFFFFF)) begin
      return 32'sh7FFFFFFF;
    end else if (r < -(XW+1)'(32'sh7FFFFFFF) - (XW+1)'(1)) begin
      return 32'sh80000000;
    end
    return OUT_W'(r);
  endfunction

  // Stage 1: radians to degrees, undo the polar half-turn fold
  always_comb begin
    p1_next.kind   = in_data.kind;
    p1_next.origin = in_data.origin;
    p1_next.tp     = TPW'($signed(in_data.z[TW-1:0])) * TPW'(RAD2DEG_S);
    p1_next.xf     = in_data.flip ? -in_data.x : in_data.x;
    p1_next.yf     = in_data.flip ? -in_data.y : in_data.y;
  end

  // Stage 2: round, clamp the angle, zero the origin
  always_comb begin
    logic signed [TPW:0] tr;
    tr = ((TPW+1)'(p1.tp) + ((TPW+1)'(1) <<< (RAD_SH - 1))) >>> RAD_SH;
    if (tr > (TPW+1)'(LIM_S)) tr = (TPW+1)'(LIM_S);
    if (tr < -(TPW+1)'(LIM_S)) tr = -(TPW+1)'(LIM_S);
    first_next  = sat_round(p1.xf);
    second_next = p1.kind ? sat_round(p1.yf) : OUT_W'(tr);
    if (p1.origin) begin
      first_next  = '0;
      second_next = '0;
    end
  end

  assign en2      = !result_valid || result_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (en1) p1 <= p1_next;
    if (en2) begin
      first_result  <= first_next;
      second_result <= second_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) result_valid <= v1;
    end
  end

  // Polar-mode angle output stays within a half turn
  a_angle_limit: assert property (@(posedge clk) disable iff (rst)
    (en2 && v1 && !p1.kind) |=> (second_result <= LIM_S && second_result >= -LIM_S))
    else $error("angle result beyond half turn");

  // Origin gives zeros on both results
  a_origin_zero: assert property (@(posedge clk) disable iff (rst)
    (en2 && v1 && p1.origin) |=> (first_result == '0 && second_result == '0))
    else $error("origin word not zeroed");

endmodule

[design/rect_polar_converter_core.sv]
// Rectangular/polar converter, one word per clock unless result_ready stalls.
// Operand channel (operand_valid/operand_ready) carries kind plus two signed
// Q15.16 operands: kind 0 takes x, y and returns magnitude and angle in
// degrees (-180..180, zero at the origin); kind 1 takes magnitude and angle
// in degrees and returns x, y. Results leave on result_valid/result_ready.
// Words pass through 33 register stages: 7 front-end stages (gain multiply,
// angle reduction modulo 360, degree to radian), 24 CORDIC stages (one
// micro-rotation each) and 2 back-end stages (radian to degree, rounding and
// saturation, the last being the output register).
// Throughput is one word per cycle unless result_ready stalls; every stage is
// fully registered and the deepest path is one multiply of at most 34x31 bits or one wide add per stage.
// Reset (rst, synchronous) clears all stage valid bits; no results are
// pending afterward and data registers are not cleared.
// When the receiver stalls, the output word holds and each stage keeps
// accepting while a bubble sits ahead of it, so operand_ready drops only
// once all 33 stages hold words.
module rect_polar_converter_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             operand_valid,
  output logic                             operand_ready,
  input  logic                             kind,
  input  logic signed [rpc_pkg::IN_W-1:0]  first_operand,
  input  logic signed [rpc_pkg::IN_W-1:0]  second_operand,
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic signed [rpc_pkg::OUT_W-1:0] first_result,
  output logic signed [rpc_pkg::OUT_W-1:0] second_result
);
  import rpc_pkg::*;

  cord_t prep_data;
  cord_t rot_data;
  logic  prep_valid;
  logic  prep_ready;
  logic  rot_valid;
  logic  rot_ready;

  // Front end: scaling and angle reduction
  rpc_prep u_prep (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (operand_valid),
    .in_ready      (operand_ready),
    .kind          (kind),
    .first_operand (first_operand),
    .second_operand(second_operand),
    .out_valid     (prep_valid),
    .out_ready     (prep_ready),
    .out_data      (prep_data)
  );

  // Rotator
  rpc_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .in_valid (prep_valid),
    .in_ready (prep_ready),
    .in_data  (prep_data),
    .out_valid(rot_valid),
    .out_ready(rot_ready),
    .out_data (rot_data)
  );

  // Back end: conversion, rounding, output register
  rpc_post u_post (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (rot_valid),
    .in_ready     (rot_ready),
    .in_data      (rot_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .first_result (first_result),
    .second_result(second_result)
  );

endmodule
